@@ src/hoc_pkg.sv @@
// Shared types, constants and codes of the horizon occlusion cull block.
package hoc_pkg;

   // Horizon geometry
   localparam int COLUMNS = 256;
   localparam int COL_W   = $clog2(COLUMNS);

   // Arithmetic widths
   localparam int ACC_W = 53;          // exact lateral and depth sums
   localparam int NUM_W = ACC_W - 16;  // floored Q16.16 values fed to the divider
   localparam int Q_BITS = 31;         // quotient bits below the saturation point
   localparam int P_W = 64;            // column position in Q.32

   localparam logic signed [31:0] SLOPE_MAX     = 32'sh7fffffff;
   localparam logic signed [31:0] SLOPE_MIN     = -32'sh7fffffff;
   localparam logic signed [31:0] SLOPE_NEG_INF = 32'sh80000000;
   localparam logic signed [15:0] K033          = 16'sd21627;   // 0.33 in Q0.16
   localparam logic signed [48:0] HALF_Q32      = 49'sh0_8000_0000;
   localparam logic signed [P_W-1:0] CEIL_ADD   = 64'sh0000_0000_ffff_ffff;
   localparam logic signed [31:0] LAST_COL      = 32'(COLUMNS - 1);

   // Input actions
   typedef enum logic [1:0] {
      ACT_CLEAR = 2'd0,
      ACT_ADD   = 2'd1,
      ACT_TEST  = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   // Configuration register indexes
   typedef enum logic [2:0] {
      REG_ENABLE   = 3'd0,
      REG_CAM_X    = 3'd1,
      REG_CAM_Y    = 3'd2,
      REG_CAM_Z    = 3'd3,
      REG_VIEW_X   = 3'd4,
      REG_VIEW_Y   = 3'd5,
      REG_TERR_TOP = 3'd6,
      REG_UNUSED   = 3'd7
   } reg_index_type;

   // Product terms of one corner
   typedef enum logic [1:0] {
      TERM_VY_DX = 2'd0,
      TERM_VX_DY = 2'd1,
      TERM_VX_DX = 2'd2,
      TERM_VY_DY = 2'd3
   } term_type;

   // Division operand select
   typedef enum logic [1:0] {
      SEL_LAT  = 2'd0,
      SEL_ZMIN = 2'd1,
      SEL_ZMAX = 2'd2,
      SEL_NONE = 2'd3
   } div_sel_type;

   // Controller to datapath
   typedef struct packed {
      logic             load;
      logic             clear;
      logic             mul_en;
      logic [1:0]       corner;
      term_type         term;
      logic             div_start;
      div_sel_type      div_sel;
      logic             occ_set;
      logic             rd_en;
      logic             rd_add;
      logic [COL_W-1:0] addr;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic             cull_off;
      logic             dep_bad;
      logic             div_done;
      logic             outer_empty;
      logic             inner_empty;
      logic [COL_W-1:0] outer_lo;
      logic [COL_W-1:0] outer_hi;
      logic [COL_W-1:0] inner_lo;
      logic [COL_W-1:0] inner_hi;
      logic             occluded;
   } status_type;

endpackage

@@ src/hoc_div.sv @@
// Radix-2 restoring divider for saturated Q16.16 slope quotients.
module hoc_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic signed [hoc_pkg::NUM_W-1:0] num,
   input  logic        [hoc_pkg::NUM_W-1:0] den,
   output logic                             done,
   output logic signed [31:0]               quot
);

   logic                        run_ff, done_ff;
   logic [4:0]                  cnt_ff;
   logic [hoc_pkg::NUM_W:0]     rem_ff;
   logic [hoc_pkg::Q_BITS-1:0]  sh_ff, q_ff;
   logic [hoc_pkg::NUM_W-1:0]   den_ff;
   logic                        neg_ff, sat_ff;
   logic signed [31:0]          quot_ff;

   logic [hoc_pkg::NUM_W-1:0]   mag;
   logic                        sat;
   logic [hoc_pkg::NUM_W:0]     r2, rem_in;
   logic                        ge;
   logic [hoc_pkg::Q_BITS-1:0]  q_in, q_fin;

   // Take magnitude and check saturation up front
   assign mag = num[hoc_pkg::NUM_W-1] ? hoc_pkg::NUM_W'(-num) : hoc_pkg::NUM_W'(num);
   assign sat = {15'b0, mag} >= {den, 15'b0};

   // One quotient bit per cycle
   assign r2     = {rem_ff[hoc_pkg::NUM_W-1:0], sh_ff[hoc_pkg::Q_BITS-1]};
   assign ge     = r2 >= {1'b0, den_ff};
   assign rem_in = ge ? r2 - {1'b0, den_ff} : r2;
   assign q_in   = {q_ff[hoc_pkg::Q_BITS-2:0], ge};
   assign q_fin  = sat_ff ? {hoc_pkg::Q_BITS{1'b1}} : q_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= 5'(hoc_pkg::Q_BITS - 1);
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Operand and quotient registers
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= (hoc_pkg::NUM_W + 1)'(mag >> 15);
         sh_ff  <= {mag[14:0], 16'b0};
         q_ff   <= '0;
         den_ff <= den;
         neg_ff <= num[hoc_pkg::NUM_W-1];
         sat_ff <= sat;
      end else if (run_ff) begin
         rem_ff <= rem_in;
         sh_ff  <= {sh_ff[hoc_pkg::Q_BITS-2:0], 1'b0};
         q_ff   <= q_in;
         if (cnt_ff == 5'd0)
            quot_ff <= neg_ff ? -$signed({1'b0, q_fin}) : $signed({1'b0, q_fin});
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

@@ src/hoc_dpath.sv @@
// Datapath: registers, projection arithmetic, column mapping and horizon memory.
module hoc_dpath (
   input  logic                   clock,
   input  logic                   reset,
   input  hoc_pkg::cmd_type       cmd,
   output hoc_pkg::status_type    status,
   input  logic                   csr_valid,
   input  logic [2:0]             csr_index,
   input  logic [31:0]            csr_wdata,
   input  logic signed [31:0]     req_box_min_x,
   input  logic signed [31:0]     req_box_min_y,
   input  logic signed [31:0]     req_box_min_z,
   input  logic signed [31:0]     req_box_max_x,
   input  logic signed [31:0]     req_box_max_y,
   input  logic signed [31:0]     req_box_max_z,
   output logic                   rsp_occluded,
   output logic                   rsp_horizon_raised
);

   // Configuration registers
   logic               en_ff;
   logic signed [31:0] cam_x_ff, cam_y_ff, cam_z_ff, top_ff;
   logic signed [17:0] vdx_ff, vdy_ff;

   // Item registers
   logic signed [31:0] bx_ff [2];
   logic signed [31:0] by_ff [2];
   logic signed [32:0] dzmin_ff, dzmax_ff;

   // Projection
   logic signed [hoc_pkg::ACC_W-1:0] lat_ff [4];
   logic signed [hoc_pkg::ACC_W-1:0] dep_ff [4];
   logic signed [50:0]  prod_ff;
   logic                pvld_ff;
   logic [1:0]          pcorner_ff;
   hoc_pkg::term_type   pterm_ff;

   logic signed [32:0]  dx, dy, b_op;
   logic signed [17:0]  a_op;
   logic signed [50:0]  prod;
   logic                dep_bad;

   // Division
   hoc_pkg::div_sel_type dsel_ff;
   logic signed [hoc_pkg::NUM_W-1:0] div_num;
   logic        [hoc_pkg::NUM_W-1:0] div_den;
   logic                div_done;
   logic signed [31:0]  div_q;
   logic signed [31:0]  xlo_ff, xhi_ff, zlo_ff, zhi_ff;

   // Column mapping
   logic signed [48:0]              tlo_ff, thi_ff;
   logic signed [hoc_pkg::P_W-1:0]  plo_ff, phi_ff;
   logic signed [hoc_pkg::P_W-1:0]  plo_c, phi_c;
   logic signed [31:0]  flo, clo, fhi, chi;
   logic signed [31:0]  olo_ff, ohi_ff, ilo_ff, ihi_ff;

   // Horizon memory and walk
   logic [31:0]               mem [hoc_pkg::COLUMNS];
   logic [hoc_pkg::COLUMNS-1:0] vld_ff;
   logic [31:0]               q_ff;
   logic                      vq_ff, pend_ff, padd_ff;
   logic [hoc_pkg::COL_W-1:0] paddr_ff;
   logic signed [31:0]        slope;
   logic                      raise;
   logic                      occ_ff, raised_ff;

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff    <= 1'b1;
         cam_x_ff <= '0;
         cam_y_ff <= '0;
         cam_z_ff <= '0;
         vdx_ff   <= '0;
         vdy_ff   <= 18'sd65536;
         top_ff   <= hoc_pkg::SLOPE_MAX;
      end else if (csr_valid) begin
         case (hoc_pkg::reg_index_type'(csr_index))
            hoc_pkg::REG_ENABLE:   en_ff    <= csr_wdata[0];
            hoc_pkg::REG_CAM_X:    cam_x_ff <= csr_wdata;
            hoc_pkg::REG_CAM_Y:    cam_y_ff <= csr_wdata;
            hoc_pkg::REG_CAM_Z:    cam_z_ff <= csr_wdata;
            hoc_pkg::REG_VIEW_X:   vdx_ff   <= csr_wdata[17:0];
            hoc_pkg::REG_VIEW_Y:   vdy_ff   <= csr_wdata[17:0];
            hoc_pkg::REG_TERR_TOP: top_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Latch the box at accept
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         bx_ff[0] <= req_box_min_x;
         bx_ff[1] <= req_box_max_x;
         by_ff[0] <= req_box_min_y;
         by_ff[1] <= req_box_max_y;
         dzmin_ff <= 33'(req_box_min_z) - 33'(cam_z_ff);
         dzmax_ff <= 33'(req_box_max_z) - 33'(cam_z_ff);
      end
   end

   // Select one product term of one corner
   assign dx = 33'(bx_ff[cmd.corner[1]]) - 33'(cam_x_ff);
   assign dy = 33'(by_ff[cmd.corner[0]]) - 33'(cam_y_ff);

   always_comb begin
      case (cmd.term)
         hoc_pkg::TERM_VY_DX: begin a_op = vdy_ff; b_op = dx; end
         hoc_pkg::TERM_VX_DY: begin a_op = vdx_ff; b_op = dy; end
         hoc_pkg::TERM_VX_DX: begin a_op = vdx_ff; b_op = dx; end
         hoc_pkg::TERM_VY_DY: begin a_op = vdy_ff; b_op = dy; end
         default:             begin a_op = vdy_ff; b_op = dx; end
      endcase
   end

   assign prod = 51'(a_op) * 51'(b_op);

   // Register the product, then accumulate it
   always_ff @(posedge clock) begin
      if (reset) begin
         pvld_ff <= 1'b0;
      end else begin
         pvld_ff <= cmd.mul_en;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff    <= prod;
      pcorner_ff <= cmd.corner;
      pterm_ff   <= cmd.term;
      if (cmd.load) begin
         for (int k = 0; k < 4; k++) begin
            lat_ff[k] <= '0;
            dep_ff[k] <= '0;
         end
      end else if (pvld_ff) begin
         case (pterm_ff)
            hoc_pkg::TERM_VY_DX:
               lat_ff[pcorner_ff] <= lat_ff[pcorner_ff] + hoc_pkg::ACC_W'(prod_ff);
            hoc_pkg::TERM_VX_DY:
               lat_ff[pcorner_ff] <= lat_ff[pcorner_ff] - hoc_pkg::ACC_W'(prod_ff);
            default:
               dep_ff[pcorner_ff] <= dep_ff[pcorner_ff] - hoc_pkg::ACC_W'(prod_ff);
         endcase
      end
   end

   // Flag a corner at or behind the camera
   always_comb begin
      dep_bad = 1'b0;
      for (int k = 0; k < 4; k++)
         if (dep_ff[k] < hoc_pkg::ACC_W'(65536))
            dep_bad = 1'b1;
   end

   assign status.dep_bad  = dep_bad;
   assign status.cull_off = !en_ff || (cam_z_ff > top_ff);

   // Feed the divider
   always_comb begin
      case (cmd.div_sel)
         hoc_pkg::SEL_ZMIN: div_num = hoc_pkg::NUM_W'(dzmin_ff);
         hoc_pkg::SEL_ZMAX: div_num = hoc_pkg::NUM_W'(dzmax_ff);
         default:           div_num = lat_ff[cmd.corner][hoc_pkg::ACC_W-1:16];
      endcase
   end
   assign div_den = dep_ff[cmd.corner][hoc_pkg::ACC_W-1:16];

   hoc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_q)
   );

   assign status.div_done = div_done;

   // Track slope extremes
   always_ff @(posedge clock) begin
      if (cmd.div_start)
         dsel_ff <= cmd.div_sel;
      if (cmd.load) begin
         xlo_ff <= hoc_pkg::SLOPE_MAX;
         xhi_ff <= hoc_pkg::SLOPE_MIN;
         zlo_ff <= hoc_pkg::SLOPE_MAX;
         zhi_ff <= hoc_pkg::SLOPE_MIN;
      end else if (div_done) begin
         case (dsel_ff)
            hoc_pkg::SEL_LAT: begin
               if (div_q < xlo_ff) xlo_ff <= div_q;
               if (div_q > xhi_ff) xhi_ff <= div_q;
            end
            hoc_pkg::SEL_ZMIN: if (div_q < zlo_ff) zlo_ff <= div_q;
            hoc_pkg::SEL_ZMAX: if (div_q > zhi_ff) zhi_ff <= div_q;
            default: ;
         endcase
      end
   end

   // Map slopes to column positions, three register stages
   assign plo_c = plo_ff + hoc_pkg::CEIL_ADD;
   assign phi_c = phi_ff + hoc_pkg::CEIL_ADD;
   assign flo   = plo_ff[hoc_pkg::P_W-1:32];
   assign clo   = plo_c[hoc_pkg::P_W-1:32];
   assign fhi   = phi_ff[hoc_pkg::P_W-1:32];
   assign chi   = phi_c[hoc_pkg::P_W-1:32];

   always_ff @(posedge clock) begin
      tlo_ff <= 49'(xlo_ff) * 49'(hoc_pkg::K033) + hoc_pkg::HALF_Q32;
      thi_ff <= 49'(xhi_ff) * 49'(hoc_pkg::K033) + hoc_pkg::HALF_Q32;
      plo_ff <= hoc_pkg::P_W'(tlo_ff) * hoc_pkg::P_W'(hoc_pkg::COLUMNS);
      phi_ff <= hoc_pkg::P_W'(thi_ff) * hoc_pkg::P_W'(hoc_pkg::COLUMNS);
      olo_ff <= (flo < 0) ? 32'sd0 : flo;
      ohi_ff <= (chi > hoc_pkg::LAST_COL) ? hoc_pkg::LAST_COL : chi;
      ilo_ff <= (clo < 0) ? 32'sd0 : clo;
      ihi_ff <= (fhi > hoc_pkg::LAST_COL) ? hoc_pkg::LAST_COL : fhi;
   end

   assign status.outer_empty = ohi_ff < olo_ff;
   assign status.inner_empty = ihi_ff < ilo_ff;
   assign status.outer_lo    = olo_ff[hoc_pkg::COL_W-1:0];
   assign status.outer_hi    = ohi_ff[hoc_pkg::COL_W-1:0];
   assign status.inner_lo    = ilo_ff[hoc_pkg::COL_W-1:0];
   assign status.inner_hi    = ihi_ff[hoc_pkg::COL_W-1:0];

   // Compare the entry read last cycle
   assign slope = vq_ff ? $signed(q_ff) : hoc_pkg::SLOPE_NEG_INF;
   assign raise = pend_ff && padd_ff && (zlo_ff > slope);

   // Horizon memory
   always_ff @(posedge clock) begin
      if (cmd.rd_en)
         q_ff <= mem[cmd.addr];
      if (raise)
         mem[paddr_ff] <= zlo_ff;
   end

   // Entry valid bits and walk pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= cmd.rd_en;
         if (cmd.clear)
            vld_ff <= '0;
         else if (raise)
            vld_ff[paddr_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      vq_ff    <= vld_ff[cmd.addr];
      padd_ff  <= cmd.rd_add;
      paddr_ff <= cmd.addr;
   end

   // Result flags
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff    <= 1'b0;
         raised_ff <= 1'b0;
      end else if (cmd.load) begin
         occ_ff    <= 1'b0;
         raised_ff <= 1'b0;
      end else begin
         if (cmd.occ_set)
            occ_ff <= 1'b1;
         else if (pend_ff && !padd_ff && (zhi_ff > slope))
            occ_ff <= 1'b0;
         if (raise)
            raised_ff <= 1'b1;
      end
   end

   assign status.occluded  = occ_ff;
   assign rsp_occluded       = occ_ff;
   assign rsp_horizon_raised = raised_ff;

endmodule

@@ src/hoc_ctrl.sv @@
// Controller: sequences projection, divisions, column walks and the response.
module hoc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [1:0]          req_action,
   input  hoc_pkg::status_type status,
   output hoc_pkg::cmd_type    cmd,
   output logic                busy,
   output logic                rsp_valid
);

   typedef enum logic [3:0] {
      S_IDLE, S_MUL, S_MDRAIN, S_CHECK, S_DIVGO, S_DIVWAIT, S_COLA, S_COLB,
      S_COLC, S_SPAN, S_TWALK, S_TDRAIN, S_TDONE, S_AWALK, S_ADRAIN, S_RESP
   } state_type;

   state_type                 state_ff, state_in;
   logic [3:0]                cnt_ff, cnt_in;
   logic [hoc_pkg::COL_W-1:0] addr_ff, addr_in;
   logic                      add_ff, add_in;
   logic                      busy_ff, rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      addr_in  = addr_ff;
      add_in   = add_ff;
      cmd      = '0;
      cmd.addr = addr_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               add_in   = (hoc_pkg::action_type'(req_action) == hoc_pkg::ACT_ADD);
               cnt_in   = '0;
               case (hoc_pkg::action_type'(req_action))
                  hoc_pkg::ACT_CLEAR: begin
                     cmd.clear = 1'b1;
                     state_in  = S_RESP;
                  end
                  hoc_pkg::ACT_ADD, hoc_pkg::ACT_TEST:
                     state_in = status.cull_off ? S_RESP : S_MUL;
                  default: state_in = S_RESP;
               endcase
            end
         end
         // Four products per corner through the shared multiplier
         S_MUL: begin
            cmd.mul_en = 1'b1;
            cmd.corner = cnt_ff[3:2];
            cmd.term   = hoc_pkg::term_type'(cnt_ff[1:0]);
            cnt_in     = cnt_ff + 4'd1;
            if (cnt_ff == 4'hf)
               state_in = S_MDRAIN;
         end
         S_MDRAIN: state_in = S_CHECK;
         S_CHECK: begin
            cnt_in   = '0;
            state_in = status.dep_bad ? S_RESP : S_DIVGO;
         end
         // Three quotients per corner
         S_DIVGO: begin
            cmd.div_start = 1'b1;
            cmd.corner    = cnt_ff[3:2];
            cmd.div_sel   = hoc_pkg::div_sel_type'(cnt_ff[1:0]);
            state_in      = S_DIVWAIT;
         end
         S_DIVWAIT: begin
            if (status.div_done) begin
               if (hoc_pkg::div_sel_type'(cnt_ff[1:0]) == hoc_pkg::SEL_ZMAX) begin
                  if (cnt_ff[3:2] == 2'd3) begin
                     state_in = S_COLA;
                  end else begin
                     cnt_in   = {cnt_ff[3:2] + 2'd1, 2'd0};
                     state_in = S_DIVGO;
                  end
               end else begin
                  cnt_in   = cnt_ff + 4'd1;
                  state_in = S_DIVGO;
               end
            end
         end
         S_COLA: state_in = S_COLB;
         S_COLB: state_in = S_COLC;
         S_COLC: state_in = S_SPAN;
         S_SPAN: begin
            if (!status.outer_empty) begin
               cmd.occ_set = 1'b1;
               addr_in     = status.outer_lo;
               state_in    = S_TWALK;
            end else if (add_ff && !status.inner_empty) begin
               addr_in  = status.inner_lo;
               state_in = S_AWALK;
            end else begin
               state_in = S_RESP;
            end
         end
         // Walk the outer span and test each entry
         S_TWALK: begin
            cmd.rd_en = 1'b1;
            if (addr_ff == status.outer_hi)
               state_in = S_TDRAIN;
            else
               addr_in = addr_ff + hoc_pkg::COL_W'(1);
         end
         S_TDRAIN: state_in = S_TDONE;
         S_TDONE: begin
            if (add_ff && !status.occluded && !status.inner_empty) begin
               addr_in  = status.inner_lo;
               state_in = S_AWALK;
            end else begin
               state_in = S_RESP;
            end
         end
         // Walk the inner span and raise entries
         S_AWALK: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_add = 1'b1;
            if (addr_ff == status.inner_hi)
               state_in = S_ADRAIN;
            else
               addr_in = addr_ff + hoc_pkg::COL_W'(1);
         end
         S_ADRAIN: state_in = S_RESP;
         S_RESP:   state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         addr_ff      <= '0;
         add_ff       <= 1'b0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         addr_ff      <= addr_in;
         add_ff       <= add_in;
         busy_ff      <= (state_in != S_IDLE);
         rsp_valid_ff <= (state_in == S_RESP);
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ src/horizon_occlusion_cull.sv @@
// Top level of the horizon occlusion cull block.
//
//   channel   ports                         transaction when
//   request   start, busy, req_*            start high and busy low at the edge
//   response  rsp_valid, rsp_*              rsp_valid high (one cycle, no stall)
//   config    csr_valid, csr_ready, csr_*   csr_valid and csr_ready high
//
// Clear, unused actions and culled items answer in the cycle right after accept.
// Add and test run the four product terms of each corner through the shared
// multiplier and settle the depths (a corner at or behind the camera answers
// next), run twelve divisions one at a time on a single radix-2 divider and map
// the slopes to columns, then read memory once per column: the outer span, and
// for an add that is not occluded the inner span; the response follows.
// Reset is synchronous; the horizon valid bits clear at once, so no sweep.
// Results cannot be stalled; one item is in flight at a time.
module horizon_occlusion_cull (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_action,
   input  logic signed [31:0] req_box_min_x,
   input  logic signed [31:0] req_box_min_y,
   input  logic signed [31:0] req_box_min_z,
   input  logic signed [31:0] req_box_max_x,
   input  logic signed [31:0] req_box_max_y,
   input  logic signed [31:0] req_box_max_z,
   output logic               rsp_valid,
   output logic               rsp_occluded,
   output logic               rsp_horizon_raised,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   hoc_pkg::cmd_type    cmd;
   hoc_pkg::status_type status;

   assign csr_ready = 1'b1;

   hoc_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_valid          (csr_valid),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_box_min_x      (req_box_min_x),
      .req_box_min_y      (req_box_min_y),
      .req_box_min_z      (req_box_min_z),
      .req_box_max_x      (req_box_max_x),
      .req_box_max_y      (req_box_max_y),
      .req_box_max_z      (req_box_max_z),
      .rsp_occluded       (rsp_occluded),
      .rsp_horizon_raised (rsp_horizon_raised)
   );

   hoc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_valid  (rsp_valid)
   );

endmodule

@@ src/hoc_checker.sv @@
// Port-level checks of the horizon occlusion cull block, bound to the top level.
module hoc_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_occluded,
   input logic rsp_horizon_raised
);

   // An accepted transaction keeps the block busy
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   // A response lasts one cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response held longer than one cycle");

   // A response only comes for a transaction in flight, which then ends
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy ##1 !busy)
      else $error("response outside a transaction");

   // A raise only follows a box that was not occluded
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_occluded && rsp_horizon_raised))
      else $error("occluded box raised the horizon");

endmodule

bind horizon_occlusion_cull hoc_checker u_hoc_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .rsp_valid          (rsp_valid),
   .rsp_occluded       (rsp_occluded),
   .rsp_horizon_raised (rsp_horizon_raised)
);
